[hw/rtl/ihpq_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihpq_pkg
// Shared types and constants of the indexed max-heap priority queue.
// ---------------------------------------------------------------------------
package ihpq_pkg;

   localparam int CAPACITY   = 256;
   localparam int PRIO_WIDTH = 32;
   localparam int ID_COUNT   = 256;
   localparam int ID_W       = 8;
   localparam int POS_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int KEY_W      = PRIO_WIDTH;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [ID_W-1:0]  id_type;
   typedef logic [KEY_W-1:0] key_type;

   typedef struct packed {
      id_type  id;
      key_type key;
   } slot_type;

   localparam logic [1:0] REQ_INSERT  = 2'd0;
   localparam logic [1:0] REQ_EXTRACT = 2'd1;
   localparam logic [1:0] REQ_CHANGE  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_CONFLICT = 2'd3;

   // heap memory port bundle
   typedef struct packed {
      logic     rd_en;
      pos_type  rd_addr;
      logic     wr_en;
      pos_type  wr_addr;
      slot_type wr_data;
   } heap_port_type;

   // position map port bundle
   typedef struct packed {
      logic    rd_en;
      id_type  rd_addr;
      logic    wr_en;
      id_type  wr_addr;
      logic    wr_present;
      pos_type wr_pos;
   } map_port_type;

   function automatic key_type prio_key(input logic [31:0] raw);
      key_type k;
      k = raw[KEY_W-1:0];
      k[KEY_W-1] = ~k[KEY_W-1];
      return k;
   endfunction

endpackage

[hw/rtl/ihpq_heap_mem.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihpq_heap_mem
// Heap array of (id, key) pairs: one write and one registered read port.
// ---------------------------------------------------------------------------
module ihpq_heap_mem (
   input  logic                   clock,
   input  ihpq_pkg::heap_port_type port,
   output ihpq_pkg::slot_type     rd_data
);
   import ihpq_pkg::*;

   slot_type mem [CAPACITY];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.wr_addr] <= port.wr_data;
      end
      if (port.rd_en) begin
         rd_data_ff <= mem[port.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ihpq_pos_map.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihpq_pos_map
// Map from id to heap position, with a presence flag per id in flip-flops.
// ---------------------------------------------------------------------------
module ihpq_pos_map (
   input  logic                  clock,
   input  logic                  reset,
   input  ihpq_pkg::map_port_type port,
   output logic                  rd_present,
   output ihpq_pkg::pos_type     rd_pos
);
   import ihpq_pkg::*;

   pos_type             mem [ID_COUNT];
   logic [ID_COUNT-1:0] present_ff;
   pos_type             rd_pos_ff;
   logic                rd_present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         rd_present_ff <= 1'b0;
      end else begin
         if (port.wr_en) begin
            present_ff[port.wr_addr] <= port.wr_present;
         end
         if (port.rd_en) begin
            rd_present_ff <= present_ff[port.rd_addr];
         end
      end
      if (port.wr_en) begin
         mem[port.wr_addr] <= port.wr_pos;
      end
      if (port.rd_en) begin
         rd_pos_ff <= mem[port.rd_addr];
      end
   end

   assign rd_present = rd_present_ff;
   assign rd_pos     = rd_pos_ff;

endmodule

[hw/rtl/ihpq_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihpq_ctrl
// Request sequencer: checks, sift up, sift down, result register.
// ---------------------------------------------------------------------------
module ihpq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [1:0]              req_type,
   input  ihpq_pkg::id_type        req_id,
   input  logic [31:0]             req_prio,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output ihpq_pkg::id_type        rsp_id,
   output logic [1:0]              rsp_status,
   output ihpq_pkg::cnt_type       rsp_count,
   output ihpq_pkg::heap_port_type hp,
   input  ihpq_pkg::slot_type      hp_rd,
   output ihpq_pkg::map_port_type  mp,
   input  logic                    mp_present,
   input  ihpq_pkg::pos_type       mp_pos
);
   import ihpq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_EXT_ROOT, S_EXT_LAST, S_UP_RD, S_UP_CMP,
      S_DN_RDL, S_DN_RDR, S_DN_CMP, S_DN_SWAP, S_DONE
   } state_type;

   state_type state_ff;
   logic [1:0] op_ff;
   id_type     id_ff;
   key_type    key_ff;
   cnt_type    count_ff;
   logic [CNT_W:0] pos_ff;   // current position (wide to hold children)
   slot_type   cur_ff;       // item being placed/sifted
   slot_type   big_ff;
   logic [CNT_W:0] big_pos_ff;
   logic       rsp_valid_ff;
   id_type     rsp_id_ff;
   logic [1:0] rsp_status_ff;

   logic [CNT_W:0] lpos, rpos, ppos;
   assign lpos = {pos_ff[CNT_W-1:0], 1'b1};
   assign rpos = {pos_ff[CNT_W-1:0], 1'b0} + (CNT_W+1)'(2);
   assign ppos = (pos_ff - (CNT_W+1)'(1)) >> 1;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_id     = rsp_id_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = count_ff;

   always_comb begin
      hp = '0;
      mp = '0;
      case (state_ff)
         S_IDLE: begin
            mp.rd_en   = req_tvalid && req_tready;
            mp.rd_addr = req_id;
            hp.rd_en   = req_tvalid && req_tready;
            hp.rd_addr = '0;
         end
         S_CHECK: begin
            if (op_ff == REQ_EXTRACT) begin
               hp.rd_en   = 1'b1;
               hp.rd_addr = POS_W'(count_ff - cnt_type'(1));
            end
         end
         S_EXT_ROOT: begin
            mp.wr_en   = 1'b1;
            mp.wr_addr = rsp_id_ff;
         end
         S_UP_RD: begin
            hp.rd_en   = 1'b1;
            hp.rd_addr = ppos[POS_W-1:0];
         end
         S_UP_CMP: begin
            if (pos_ff != '0 && hp_rd.key < cur_ff.key) begin
               hp.wr_en   = 1'b1;
               hp.wr_addr = pos_ff[POS_W-1:0];
               hp.wr_data = hp_rd;
               mp.wr_en   = 1'b1;
               mp.wr_addr = hp_rd.id;
               mp.wr_present = 1'b1;
               mp.wr_pos  = pos_ff[POS_W-1:0];
            end else begin
               hp.wr_en   = 1'b1;
               hp.wr_addr = pos_ff[POS_W-1:0];
               hp.wr_data = cur_ff;
               mp.wr_en   = 1'b1;
               mp.wr_addr = cur_ff.id;
               mp.wr_present = 1'b1;
               mp.wr_pos  = pos_ff[POS_W-1:0];
            end
         end
         S_DN_RDL: begin
            hp.rd_en   = 1'b1;
            hp.rd_addr = lpos[POS_W-1:0];
         end
         S_DN_RDR: begin
            hp.rd_en   = 1'b1;
            hp.rd_addr = rpos[POS_W-1:0];
         end
         S_DN_SWAP: begin
            hp.wr_en   = 1'b1;
            hp.wr_addr = pos_ff[POS_W-1:0];
            hp.wr_data = big_ff;
            mp.wr_en   = 1'b1;
            mp.wr_addr = big_ff.id;
            mp.wr_present = 1'b1;
            mp.wr_pos  = pos_ff[POS_W-1:0];
         end
         S_DN_CMP: begin
            hp.wr_en   = 1'b1;
            hp.wr_addr = pos_ff[POS_W-1:0];
            hp.wr_data = cur_ff;
            mp.wr_en   = 1'b1;
            mp.wr_addr = cur_ff.id;
            mp.wr_present = 1'b1;
            mp.wr_pos  = pos_ff[POS_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_DONE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  op_ff    <= req_type;
                  id_ff    <= req_id;
                  key_ff   <= prio_key(req_prio);
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               cur_ff <= '{id: id_ff, key: key_ff};
               case (op_ff)
                  REQ_INSERT: begin
                     rsp_id_ff <= '0;
                     if (count_ff >= cnt_type'(CAPACITY)) begin
                        rsp_status_ff <= ST_FULL;
                        state_ff      <= S_DONE;
                     end else if (mp_present) begin
                        rsp_status_ff <= ST_CONFLICT;
                        state_ff      <= S_DONE;
                     end else begin
                        rsp_status_ff <= ST_OK;
                        pos_ff        <= {1'b0, count_ff};
                        count_ff      <= count_ff + cnt_type'(1);
                        state_ff      <= S_UP_RD;
                     end
                  end
                  REQ_EXTRACT: begin
                     if (count_ff == '0) begin
                        rsp_id_ff     <= '0;
                        rsp_status_ff <= ST_EMPTY;
                        state_ff      <= S_DONE;
                     end else begin
                        rsp_id_ff     <= hp_rd.id;
                        rsp_status_ff <= ST_OK;
                        count_ff      <= count_ff - cnt_type'(1);
                        state_ff      <= S_EXT_ROOT;
                     end
                  end
                  REQ_CHANGE: begin
                     rsp_id_ff <= '0;
                     if (!mp_present) begin
                        rsp_status_ff <= ST_CONFLICT;
                        state_ff      <= S_DONE;
                     end else begin
                        rsp_status_ff <= ST_OK;
                        pos_ff   <= ({1'b0, cnt_type'(mp_pos)} >= {1'b0, count_ff}) ?
                                    '0 : {1'b0, cnt_type'(mp_pos)};
                        state_ff <= S_UP_RD;
                     end
                  end
                  default: begin
                     rsp_id_ff     <= '0;
                     rsp_status_ff <= ST_OK;
                     state_ff      <= S_DONE;
                  end
               endcase
            end
            S_EXT_ROOT: begin
               state_ff <= S_EXT_LAST;
            end
            S_EXT_LAST: begin
               cur_ff   <= hp_rd;
               pos_ff   <= '0;
               state_ff <= (count_ff == '0) ? S_DONE : S_DN_RDL;
            end
            S_UP_RD: begin
               state_ff <= S_UP_CMP;
            end
            S_UP_CMP: begin
               if (pos_ff != '0 && hp_rd.key < cur_ff.key) begin
                  pos_ff   <= ppos;
                  state_ff <= S_UP_RD;
               end else begin
                  state_ff <= (op_ff == REQ_CHANGE) ? S_DN_RDL : S_DONE;
               end
            end
            S_DN_RDL: begin
               state_ff <= S_DN_RDR;
            end
            S_DN_RDR: begin
               state_ff <= S_DN_CMP;
               if (lpos < {1'b0, count_ff} && hp_rd.key > cur_ff.key) begin
                  big_ff     <= hp_rd;
                  big_pos_ff <= lpos;
               end else begin
                  big_ff     <= cur_ff;
                  big_pos_ff <= pos_ff;
               end
            end
            S_DN_CMP: begin
               if (rpos < {1'b0, count_ff} && hp_rd.key > big_ff.key) begin
                  big_ff     <= hp_rd;
                  big_pos_ff <= rpos;
                  state_ff   <= S_DN_SWAP;
               end else if (big_pos_ff != pos_ff) begin
                  state_ff   <= S_DN_SWAP;
               end else begin
                  state_ff   <= S_DONE;
               end
            end
            S_DN_SWAP: begin
               pos_ff   <= big_pos_ff;
               state_ff <= S_DN_RDL;
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(CAPACITY))
      else $error("count above capacity");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("ready while busy");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_tvalid)
      else $error("result lost");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status != ST_OK) |-> rsp_id == '0)
      else $error("id on error result");

endmodule

[hw/rtl/indexed_max_heap_pq_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_max_heap_pq_unit
// Indexed binary max-heap priority queue over 256 ids.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: tuser = request kind (0 insert, 1 extract max, 2 change),
//   tdata = {prio_value[31:0], item_id[7:0]}. Each request returns one beat
//   on rsp: tdata = {queue_count, status, out_item_id}, padded to 24 bits.
//   One request is in flight at a time; ready stays low from acceptance until
//   its result beat has been taken. A rejected or ignored request goes from
//   the check straight to its result; a sift up reads the parent and moves
//   one slot per level; a sift down reads both children per level and swaps
//   with the larger one while it beats the item. Heap reads are registered.
//   Reset clears the count and the id presence flags; heap contents need no
//   clearing. A stalled rsp beat holds and blocks new input.
// ---------------------------------------------------------------------------
module indexed_max_heap_pq_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // item_id[7:0], prio_value[39:8]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // out_item_id[7:0], status[9:8], queue_count[18:10]
);
   import ihpq_pkg::*;

   heap_port_type hp;
   slot_type      hp_rd;
   map_port_type  mp;
   logic          mp_present;
   pos_type       mp_pos;
   id_type        rsp_id;
   logic [1:0]    rsp_status;
   cnt_type       rsp_count;

   ihpq_heap_mem u_heap (
      .clock   (clock),
      .port    (hp),
      .rd_data (hp_rd)
   );

   ihpq_pos_map u_map (
      .clock      (clock),
      .reset      (reset),
      .port       (mp),
      .rd_present (mp_present),
      .rd_pos     (mp_pos)
   );

   ihpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .req_id     (req_tdata[7:0]),
      .req_prio   (req_tdata[39:8]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_id     (rsp_id),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count),
      .hp         (hp),
      .hp_rd      (hp_rd),
      .mp         (mp),
      .mp_present (mp_present),
      .mp_pos     (mp_pos)
   );

   assign rsp_tdata = {5'd0, rsp_count, rsp_status, rsp_id};

endmodule

[sim/indexed_max_heap_pq_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_max_heap_pq_unit_tb
// Self-checking bench for the indexed max-heap priority queue. A short
// directed table covers the empty, duplicate and absent-id cases and
// the priority extremes. A fill to capacity and a long random mix of
// inserts, extracts and priority changes follow. A local heap model predicts
// the beats that the table does not fix; the bench compares each field of
// each beat against the expected one. The sender and the receiver idle at
// random in several phases; one long receiver hold-off stalls the input.
// ---------------------------------------------------------------------------
module indexed_max_heap_pq_unit_tb;
   import ihpq_pkg::*;

   typedef struct packed {
      logic [8:0] count;
      logic [1:0] status;
      logic [7:0] out_id;
   } rsp_beat_type;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  id;
      logic [31:0] prio;
      bit          fixed;
      logic [7:0]  out_id;
      logic [1:0]  status;
      logic [8:0]  count;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // item_id[7:0], prio_value[39:8]
   logic [1:0]  req_tuser;   // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // out_item_id[7:0], status[9:8], queue_count[18:10]

   logic [7:0]  heap_id [CAPACITY];
   logic [31:0] heap_key [CAPACITY];
   int unsigned pos_of [ID_COUNT];
   bit          queued [ID_COUNT];
   int unsigned queued_count;

   rsp_beat_type pending_rsp [$];
   int           errors = 0;
   int           send_gap_pct;
   int           stall_pct;
   event         hold_go;
   logic         hold_active;
   logic         rsp_tvalid_s;
   logic [23:0]  rsp_tdata_s;
   logic         rsp_tready_s;
   row_type      directed [$];

   indexed_max_heap_pq_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(12 * 3_000_000);
      $display("FAIL indexed_max_heap_pq_unit");
      $finish;
   end

   function automatic void put_slot(int unsigned pos, logic [7:0] id, logic [31:0] key);
      heap_id[pos]  = id;
      heap_key[pos] = key;
      pos_of[id]    = pos;
   endfunction

   function automatic int unsigned lift(int unsigned pos, logic [31:0] key);
      while (pos >= 1 && heap_key[(pos - 1) / 2] < key) begin
         put_slot(pos, heap_id[(pos - 1) / 2], heap_key[(pos - 1) / 2]);
         pos = (pos - 1) / 2;
      end
      return pos;
   endfunction

   function automatic void sink(int unsigned pos);
      int unsigned l, r, big;
      logic [7:0]  tid;
      logic [31:0] tkey;
      forever begin
         l = 2 * pos + 1;
         r = 2 * pos + 2;
         big = pos;
         if (l < queued_count && heap_key[l] > heap_key[big]) big = l;
         if (r < queued_count && heap_key[r] > heap_key[big]) big = r;
         if (big == pos) return;
         tid  = heap_id[pos];
         tkey = heap_key[pos];
         put_slot(pos, heap_id[big], heap_key[big]);
         put_slot(big, tid, tkey);
         pos = big;
      end
   endfunction

   function automatic rsp_beat_type serve_request(logic [1:0] kind, logic [7:0] id,
                                                  logic [31:0] prio);
      rsp_beat_type res;
      logic [31:0]  key;
      int unsigned  pos;
      key = {~prio[31], prio[30:0]};
      res = '0;
      case (kind)
         REQ_INSERT: begin
            if (queued_count >= CAPACITY) res.status = ST_FULL;
            else if (queued[id]) res.status = ST_CONFLICT;
            else begin
               pos = queued_count;
               queued_count++;
               pos = lift(pos, key);
               put_slot(pos, id, key);
               queued[id] = 1'b1;
            end
         end
         REQ_EXTRACT: begin
            if (queued_count == 0) res.status = ST_EMPTY;
            else begin
               res.out_id = heap_id[0];
               queued[heap_id[0]] = 1'b0;
               queued_count--;
               if (queued_count > 0) begin
                  put_slot(0, heap_id[queued_count], heap_key[queued_count]);
                  sink(0);
               end
            end
         end
         REQ_CHANGE: begin
            if (!queued[id]) res.status = ST_CONFLICT;
            else begin
               pos = pos_of[id];
               if (pos >= queued_count) pos = 0;
               pos = lift(pos, key);
               put_slot(pos, id, key);
               sink(pos);
            end
         end
         default: ;
      endcase
      res.count = queued_count[8:0];
      return res;
   endfunction

   // ---- long receiver hold-off ----
   initial begin
      hold_active = 1'b0;
      @(hold_go);
      hold_active <= 1'b1;
      repeat (400) @(posedge clock);
      hold_active <= 1'b0;
   end

   // ---- response side ----
   always @(negedge clock) begin
      rsp_tvalid_s <= rsp_tvalid;
      rsp_tdata_s  <= rsp_tdata;
      rsp_tready_s <= rsp_tready;
   end

   always @(posedge clock) begin
      rsp_beat_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid_s && rsp_tready_s) begin
            got = rsp_tdata_s[18:0];
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, rsp_tdata_s);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (got.out_id !== want.out_id) begin
                  $display("%0t: out_item_id expected %0d actual %0d", $time,
                           want.out_id, got.out_id);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, got.status);
                  errors++;
               end
               if (got.count !== want.count) begin
                  $display("%0t: queue_count expected %0d actual %0d", $time,
                           want.count, got.count);
                  errors++;
               end
               if (rsp_tdata_s[23:19] !== 5'd0) begin
                  $display("%0t: padding expected 0 actual %h", $time, rsp_tdata_s[23:19]);
                  errors++;
               end
            end
         end
         if (hold_active) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // ---- request side ----
   task automatic send_beat(logic [1:0] kind, logic [7:0] id, logic [31:0] prio,
                            bit fixed, rsp_beat_type typed);
      bit           rdy;
      rsp_beat_type pred;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {prio, id};
      do begin
         @(negedge clock);
         rdy = req_tready;
         @(posedge clock);
      end while (!rdy);
      pred = serve_request(kind, id, prio);
      pending_rsp.push_back(fixed ? typed : pred);
   endtask

   function automatic logic [31:0] pick_prio();
      case ($urandom_range(4))
         0: return $urandom_range(8) - 4;
         1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return $urandom_range(15) << 28;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pick_id(bit want_queued);
      logic [7:0] id;
      for (int t = 0; t < 12; t++) begin
         id = 8'($urandom_range(255));
         if (queued[id] == want_queued) return id;
      end
      return id;
   endfunction

   task automatic random_mix(int n);
      int          r;
      logic [1:0]  kind;
      logic [7:0]  id;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 3) kind = 2'd3;
         else if (r < 50) kind = REQ_INSERT;
         else if (r < 80) kind = REQ_EXTRACT;
         else kind = REQ_CHANGE;
         if (kind == REQ_CHANGE) id = pick_id($urandom_range(99) < 85);
         else if (kind == REQ_INSERT) id = pick_id($urandom_range(99) >= 80);
         else id = 8'($urandom);
         send_beat(kind, id, pick_prio(), 1'b0, '0);
      end
   endtask

   function automatic void add_row(logic [1:0] kind, logic [7:0] id, logic [31:0] prio,
                                   bit fixed, logic [7:0] out_id, logic [1:0] status,
                                   logic [8:0] count);
      row_type row;
      row.kind = kind; row.id = id; row.prio = prio; row.fixed = fixed;
      row.out_id = out_id; row.status = status; row.count = count;
      directed.push_back(row);
   endfunction

   initial begin
      rsp_beat_type typed;
      logic [7:0]   order [256];
      int           j;
      logic [7:0]   tmp;
      send_gap_pct = 0;
      stall_pct = 0;
      queued_count = 0;
      for (int i = 0; i < ID_COUNT; i++) queued[i] = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(REQ_EXTRACT, 8'd0,   32'd0,        1, 8'd0, ST_EMPTY,    9'd0);
      add_row(REQ_CHANGE,  8'd5,   32'd7,        1, 8'd0, ST_CONFLICT, 9'd0);
      add_row(2'd3,        8'd9,   32'd9,        1, 8'd0, ST_OK,       9'd0);
      add_row(REQ_INSERT,  8'd0,   32'h7FFF_FFFF, 1, 8'd0, ST_OK,      9'd1);
      add_row(REQ_INSERT,  8'd255, 32'h8000_0000, 1, 8'd0, ST_OK,      9'd2);
      add_row(REQ_INSERT,  8'd0,   32'd1,        1, 8'd0, ST_CONFLICT, 9'd2);
      add_row(REQ_INSERT,  8'd170, 32'h5555_5555, 0, 8'd0, ST_OK,      9'd0);
      add_row(REQ_INSERT,  8'd85,  32'hAAAA_AAAA, 0, 8'd0, ST_OK,      9'd0);
      add_row(REQ_INSERT,  8'd1,   32'h7FFF_FFFF, 0, 8'd0, ST_OK,      9'd0);
      add_row(REQ_CHANGE,  8'd255, 32'h7FFF_FFFF, 0, 8'd0, ST_OK,      9'd0);
      add_row(REQ_CHANGE,  8'd0,   32'h8000_0000, 0, 8'd0, ST_OK,      9'd0);
      add_row(2'd3,        8'd255, 32'hFFFF_FFFF, 1, 8'd0, ST_OK,      9'd5);
      for (int i = 0; i < 5; i++) add_row(REQ_EXTRACT, 8'd0, 32'd0, 0, 8'd0, ST_OK, 9'd0);
      add_row(REQ_EXTRACT, 8'd0,   32'd0,        1, 8'd0, ST_EMPTY,    9'd0);
      foreach (directed[i]) begin
         typed = '{count: directed[i].count, status: directed[i].status,
                   out_id: directed[i].out_id};
         send_beat(directed[i].kind, directed[i].id, directed[i].prio,
                   directed[i].fixed, typed);
      end

      // fill to capacity in shuffled id order, then push past full
      for (int i = 0; i < 256; i++) order[i] = 8'(i);
      for (int i = 255; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = order[i]; order[i] = order[j]; order[j] = tmp;
      end
      send_gap_pct = 21;
      stall_pct = 21;
      for (int i = 0; i < 256; i++) begin
         if (i == 100) begin
            send_gap_pct = 0;
            -> hold_go;
         end
         send_beat(REQ_INSERT, order[i], pick_prio(), 1'b0, '0);
      end
      for (int i = 0; i < 4; i++) send_beat(REQ_INSERT, 8'($urandom), pick_prio(), 1'b0, '0);
      for (int i = 0; i < 20; i++) send_beat(REQ_CHANGE, 8'($urandom), pick_prio(), 1'b0, '0);

      send_gap_pct = 0;  stall_pct = 0;  random_mix(320);
      send_gap_pct = 61; stall_pct = 0;  random_mix(320);
      send_gap_pct = 0;  stall_pct = 61; random_mix(320);
      send_gap_pct = 21; stall_pct = 21; random_mix(320);
      req_tvalid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("PASS indexed_max_heap_pq_unit");
      end else begin
         $display("FAIL indexed_max_heap_pq_unit");
      end
      $finish;
   end

endmodule
